// ===== rtl/core/bvle_pkg.sv =====
// Package for the bounded value list engine.
// Holds the command codes, store sizing, shared types and field helpers.
// No dependencies.
`default_nettype none

package bvle_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int CMD_W    = 3;
    localparam int FLD_W    = 5;

    localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PREPEND   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_ALL   = 3'd4;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic              we;
        t_idx              waddr;
        logic [VAL_W-1:0]  wdata;
        logic              re;
        t_idx              raddr;
    } t_mem_req;

    typedef struct packed {
        logic             found;
        logic [FLD_W-1:0] removed_count;
        logic [FLD_W-1:0] list_length;
        logic             overflow;
    } t_result;

    // Report a count in the 5-bit result field, modulo 32.
    function automatic logic [FLD_W-1:0] to_field(input t_cnt c);
        logic [CNT_W+FLD_W-1:0] t;
        t = {{FLD_W{1'b0}}, c};
        return t[FLD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bvle_if.sv =====
// Valid/ready channels for the bounded value list engine.
// Depends on bvle_pkg.
`default_nettype none

interface bvle_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [bvle_pkg::CMD_W-1:0]        command;
    logic signed [bvle_pkg::VAL_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface bvle_res_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [bvle_pkg::FLD_W-1:0] removed_count;
    logic [bvle_pkg::FLD_W-1:0] list_length;
    logic                       overflow;

    modport source (output valid, output found, output removed_count,
                    output list_length, output overflow, input ready);
    modport sink   (input valid, input found, input removed_count,
                    input list_length, input overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bvle_store.sv =====
// Value store: one write port and one read port with registered read data.
// Depends on bvle_pkg.
`default_nettype none

module bvle_store (
    input  wire                             i_clk,
    input  bvle_pkg::t_mem_req              i_req,
    output logic [bvle_pkg::VAL_W-1:0]      o_rd_data
);
    import bvle_pkg::*;

    logic [VAL_W-1:0] r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rd_data <= r_mem[i_req.raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bvle_ctrl.sv =====
// Command sequencer: walks the store one entry per cycle through a single
// compare and index unit, shifting or compacting entries as it goes.
// Depends on bvle_pkg.
`default_nettype none

module bvle_ctrl (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cmd_valid,
    output logic                        o_cmd_ready,
    input  wire [bvle_pkg::CMD_W-1:0]   i_command,
    input  wire [bvle_pkg::VAL_W-1:0]   i_value,
    output logic                        o_res_valid,
    input  wire                         i_res_ready,
    output bvle_pkg::t_result           o_res,
    output bvle_pkg::t_mem_req          o_mem_req,
    input  wire [bvle_pkg::VAL_W-1:0]   i_rd_data
);
    import bvle_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state           r_state,    n_state;
    logic [CMD_W-1:0] r_cmd,      n_cmd;
    logic [VAL_W-1:0] r_val,      n_val;
    t_cnt             r_count,    n_count;
    t_idx             r_rd_idx,   n_rd_idx;
    t_cnt             r_rd_left,  n_rd_left;
    logic             r_pend,     n_pend;
    t_idx             r_pend_idx, n_pend_idx;
    t_idx             r_wr_idx,   n_wr_idx;
    t_cnt             r_gone,     n_gone;
    logic             r_hit,      n_hit;
    logic             r_ovf,      n_ovf;

    logic accept;
    logic full;
    logic match;

    assign accept = i_cmd_valid && o_cmd_ready;
    assign full   = (r_count == t_cnt'(CAPACITY));
    assign match  = (i_rd_data == r_val);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_val      = r_val;
        n_count    = r_count;
        n_rd_idx   = r_rd_idx;
        n_rd_left  = r_rd_left;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_wr_idx   = r_wr_idx;
        n_gone     = r_gone;
        n_hit      = r_hit;
        n_ovf      = r_ovf;
        o_mem_req  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd    = i_command;
                    n_val    = i_value;
                    n_gone   = '0;
                    n_hit    = 1'b0;
                    n_ovf    = 1'b0;
                    n_wr_idx = '0;
                    n_state  = S_DONE;
                    unique case (i_command) inside
                        CMD_APPEND: begin
                            if (full) begin
                                n_ovf = 1'b1;
                            end else begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = r_count[IDX_W-1:0];
                                o_mem_req.wdata = i_value;
                                n_count         = r_count + 1'b1;
                            end
                        end
                        CMD_PREPEND: begin
                            if (full) begin
                                n_ovf = 1'b1;
                            end else begin
                                // walk from the tail down, moving each entry up one
                                n_rd_idx  = t_idx'(r_count - 1'b1);
                                n_rd_left = r_count;
                                n_state   = S_SCAN;
                            end
                        end
                        CMD_SEARCH, CMD_DEL_FIRST, CMD_DEL_ALL: begin
                            n_rd_idx  = '0;
                            n_rd_left = r_count;
                            n_state   = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_rd_left != '0) begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = r_rd_idx;
                    n_rd_idx        = (r_cmd == CMD_PREPEND) ? r_rd_idx - 1'b1
                                                             : r_rd_idx + 1'b1;
                    n_rd_left       = r_rd_left - 1'b1;
                    n_pend          = 1'b1;
                    n_pend_idx      = r_rd_idx;
                end

                if (r_pend) begin
                    case (r_cmd)
                        CMD_PREPEND: begin
                            o_mem_req.we    = 1'b1;
                            o_mem_req.waddr = r_pend_idx + 1'b1;
                            o_mem_req.wdata = i_rd_data;
                        end
                        CMD_SEARCH: begin
                            if (match) begin
                                n_hit = 1'b1;
                            end
                        end
                        default: begin
                            // drop a matching entry, compact the kept ones
                            if (match && (r_cmd == CMD_DEL_ALL || r_gone == '0)) begin
                                n_gone = r_gone + 1'b1;
                                n_hit  = 1'b1;
                            end else begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = r_wr_idx;
                                o_mem_req.wdata = i_rd_data;
                                n_wr_idx        = r_wr_idx + 1'b1;
                            end
                        end
                    endcase
                end

                if (r_rd_left == '0 && !r_pend) begin
                    n_state = S_DONE;
                    case (r_cmd)
                        CMD_PREPEND: begin
                            o_mem_req.we    = 1'b1;
                            o_mem_req.waddr = '0;
                            o_mem_req.wdata = r_val;
                            n_count         = r_count + 1'b1;
                        end
                        default: begin
                            n_count = r_count - r_gone;
                        end
                    endcase
                end
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_cmd      <= n_cmd;
        r_val      <= n_val;
        r_rd_idx   <= n_rd_idx;
        r_rd_left  <= n_rd_left;
        r_pend_idx <= n_pend_idx;
        r_wr_idx   <= n_wr_idx;
        r_gone     <= n_gone;
        r_hit      <= n_hit;
        r_ovf      <= n_ovf;
    end

    assign o_cmd_ready         = (r_state == S_IDLE);
    assign o_res_valid         = (r_state == S_DONE);
    assign o_res.found         = r_hit;
    assign o_res.removed_count = to_field(r_gone);
    assign o_res.list_length   = to_field(r_count);
    assign o_res.overflow      = r_ovf;

endmodule

`default_nettype wire

// ===== rtl/core/bounded_value_list_engine.sv =====
// Append, overflowed insert and unused codes finish without walking the store;
// insert at head, search and deletes walk every stored entry through the read port.
// One item is taken at a time: the walk through the single store read port holds
// off the next command. A result register lets the next item in while a result waits.
// Reset (synchronous, active low) empties the list; stored values are not cleared.
// Depends on bvle_pkg, bvle_if, bvle_store, bvle_ctrl.
`default_nettype none

module bounded_value_list_engine (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bvle_cmd_if.sink    i_cmd,
    bvle_res_if.source  o_res
);
    import bvle_pkg::*;

    t_mem_req         mem_req;
    logic [VAL_W-1:0] rd_data;
    t_result          res;
    logic             res_valid;
    logic             res_ready;
    logic             r_out_valid;
    t_result          r_out;

    bvle_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    bvle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (i_cmd.ready),
        .i_command   (i_cmd.command),
        .i_value     (i_cmd.value),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_req   (mem_req),
        .i_rd_data   (rd_data)
    );

    assign res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.found         = r_out.found;
    assign o_res.removed_count = r_out.removed_count;
    assign o_res.list_length   = r_out.list_length;
    assign o_res.overflow      = r_out.overflow;

endmodule

`default_nettype wire

// ===== rtl/core/bvle_chk.sv =====
// Port-level checks for the bounded value list engine, bound to the top level.
// Depends on bvle_pkg and bounded_value_list_engine.
`default_nettype none

module bvle_chk (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_in_valid,
    input wire                        i_in_ready,
    input wire                        i_out_valid,
    input wire                        i_out_ready,
    input wire                        i_found,
    input wire [bvle_pkg::FLD_W-1:0]  i_removed_count,
    input wire                        i_overflow
);
    import bvle_pkg::*;

    // one item at a time: the command port closes right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("command port still ready after accepting an item");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    a_overflow_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_overflow) |-> (!i_found && i_removed_count == '0))
        else $error("overflowed insert reports a match or removal");

    a_removed_implies_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_removed_count != '0) |-> i_found)
        else $error("entries removed without found");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind bounded_value_list_engine bvle_chk u_bvle_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_cmd.valid),
    .i_in_ready      (i_cmd.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_found         (o_res.found),
    .i_removed_count (o_res.removed_count),
    .i_overflow      (o_res.overflow)
);

`default_nettype wire

// ===== test/bvle_list_checker.sv =====
`timescale 1ns / 100ps
// Checker for the bounded value list engine: watches the command and result channels,
// keeps its own copy of the list and compares every result item field by field.
// Depends on bvle_pkg and bvle_if.

module bvle_list_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bvle_cmd_if         i_cmd,
    bvle_res_if         i_res,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results,
    output int          o_overflows,
    output int          o_deleted
);
    import bvle_pkg::*;

    logic [VAL_W-1:0] list_vals [CAPACITY];
    int               list_len;
    t_result          pending_results [$];
    t_result          exp_r;

    // Apply one command to the shadow list and return the result it should produce.
    function automatic t_result apply_list_command(logic [CMD_W-1:0] cmd,
                                                   logic [VAL_W-1:0] val);
        t_result r;
        int      i;
        int      w;
        int      gone;
        r    = '0;
        gone = 0;
        case (cmd)
            CMD_APPEND: begin
                if (list_len >= CAPACITY) begin
                    r.overflow = 1'b1;
                end else begin
                    list_vals[list_len] = val;
                    list_len++;
                end
            end
            CMD_PREPEND: begin
                if (list_len >= CAPACITY) begin
                    r.overflow = 1'b1;
                end else begin
                    for (i = list_len; i > 0; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[0] = val;
                    list_len++;
                end
            end
            CMD_SEARCH: begin
                for (i = 0; i < list_len; i++) begin
                    if (list_vals[i] == val) begin
                        r.found = 1'b1;
                        break;
                    end
                end
            end
            CMD_DEL_FIRST: begin
                for (i = 0; i < list_len; i++) begin
                    if (list_vals[i] == val) begin
                        for (w = i; w + 1 < list_len; w++)
                            list_vals[w] = list_vals[w+1];
                        list_len--;
                        gone    = 1;
                        r.found = 1'b1;
                        break;
                    end
                end
            end
            CMD_DEL_ALL: begin
                w = 0;
                for (i = 0; i < list_len; i++) begin
                    if (list_vals[i] == val) begin
                        gone++;
                    end else begin
                        list_vals[w] = list_vals[i];
                        w++;
                    end
                end
                list_len = w;
                r.found  = (gone != 0);
            end
            default: begin
            end
        endcase
        r.removed_count = gone[FLD_W-1:0];
        r.list_length   = list_len[FLD_W-1:0];
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
        o_overflows  = 0;
        o_deleted    = 0;
        list_len     = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            pending_results.delete();
        end else begin
            // Retire the oldest expectation first; a new command cannot answer in its own cycle.
            if (i_res.valid && i_res.ready) begin
                o_results++;
                if (pending_results.size() == 0) begin
                    $error("result item with no command waiting");
                    o_fail_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    o_overflows += exp_r.overflow;
                    o_deleted   += exp_r.removed_count;
                    if (i_res.found !== exp_r.found) begin
                        $error("found: expected %0d, got %0d", exp_r.found, i_res.found);
                        o_fail_count++;
                    end
                    if (i_res.removed_count !== exp_r.removed_count) begin
                        $error("removed_count: expected %0d, got %0d",
                               exp_r.removed_count, i_res.removed_count);
                        o_fail_count++;
                    end
                    if (i_res.list_length !== exp_r.list_length) begin
                        $error("list_length: expected %0d, got %0d",
                               exp_r.list_length, i_res.list_length);
                        o_fail_count++;
                    end
                    if (i_res.overflow !== exp_r.overflow) begin
                        $error("overflow: expected %0d, got %0d",
                               exp_r.overflow, i_res.overflow);
                        o_fail_count++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                pending_results.push_back(apply_list_command(i_cmd.command, i_cmd.value));
        end
        o_pending = pending_results.size();
    end

endmodule

// ===== test/tb_bounded_value_list_engine.sv =====
`timescale 1ns / 100ps
// Testbench top for the bounded value list engine: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on bvle_pkg, bvle_if and bvle_list_checker.

module tb_bounded_value_list_engine;
    import bvle_pkg::*;

    localparam int               RANDOM_ITEMS = 1500;
    localparam int               IDLE_PCT     = 8;
    localparam int               HOLDOFF_AT   = 300;
    localparam int               HOLDOFF_LEN  = 400;
    localparam int               QUIET_FROM   = 600;
    localparam int               QUIET_TO     = 800;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 3'd5;   // codes 5..7 do nothing

    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIXED  = 2;

    logic i_clk;
    logic i_rst_n;

    bvle_cmd_if cmd_ch ();
    bvle_res_if res_ch ();

    int fail_count;
    int pending;
    int results;
    int overflows;
    int deleted;

    int items_sent;
    bit no_idle;
    bit held_off;
    int holdoff_left;

    logic [VAL_W-1:0] value_pool [4];
    int               pool_n;

    bounded_value_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    bvle_list_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_overflows  (overflows),
        .o_deleted    (deleted)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Offer one item, after a random gap, and hold it until the engine takes it.
    task automatic issue_command(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val);
        int gap;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.value   <= val;
        do @(posedge i_clk); while (!cmd_ch.ready);
        items_sent++;
    endtask

    function automatic logic [VAL_W-1:0] pick_extreme();
        case ($urandom_range(3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(99) < 75)
            return value_pool[$urandom_range(pool_n - 1)];
        return ($urandom_range(99) < 10) ? pick_extreme() : VAL_W'($urandom);
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(int mode);
        int r;
        logic [CMD_W-1:0] ins;
        r   = $urandom_range(99);
        ins = $urandom_range(1) ? CMD_APPEND : CMD_PREPEND;
        if (r >= 97)
            return CMD_UNUSED + CMD_W'($urandom_range(2));
        case (mode)
            MODE_GROW:   return (r < 70) ? ins : CMD_W'($urandom_range(CMD_SEARCH, CMD_DEL_ALL));
            MODE_SHRINK: return (r < 20) ? ins : CMD_W'($urandom_range(CMD_SEARCH, CMD_DEL_ALL));
            default:     return CMD_W'($urandom_range(CMD_APPEND, CMD_DEL_ALL));
        endcase
    endfunction

    // Result side: random stalls, one long hold-off, and a quiet stretch.
    initial begin
        res_ch.ready <= 1'b0;
        held_off     = 1'b0;
        holdoff_left = 0;
        forever begin
            @(posedge i_clk);
            if (!held_off && items_sent >= HOLDOFF_AT) begin
                held_off     = 1'b1;
                holdoff_left = HOLDOFF_LEN;
            end
            if (holdoff_left != 0) begin
                res_ch.ready <= 1'b0;
                holdoff_left--;
            end else if (no_idle) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Timeout with %0d result items still outstanding", pending);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int mode;
        int run_len;
        int n;
        items_sent     = 0;
        no_idle        = 1'b0;
        pool_n         = 1;
        i_rst_n        <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= CMD_APPEND;
        cmd_ch.value   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty list, extremes, head and tail, misses, duplicates, unused codes.
        issue_command(CMD_SEARCH,    32'h0000_0000);
        issue_command(CMD_DEL_FIRST, 32'h0000_0000);
        issue_command(CMD_DEL_ALL,   32'h0000_0000);
        issue_command(CMD_APPEND,    32'h7FFF_FFFF);
        issue_command(CMD_PREPEND,   32'h8000_0000);
        issue_command(CMD_APPEND,    32'h0000_0000);
        issue_command(CMD_APPEND,    32'hFFFF_FFFF);
        issue_command(CMD_PREPEND,   32'hFFFF_FFFF);
        issue_command(CMD_APPEND,    32'hAAAA_AAAA);
        issue_command(CMD_PREPEND,   32'h5555_5555);
        issue_command(CMD_SEARCH,    32'h8000_0000);
        issue_command(CMD_SEARCH,    32'h7FFF_FFFE);
        issue_command(CMD_SEARCH,    32'h5555_5555);
        issue_command(CMD_DEL_FIRST, 32'h1234_5678);
        issue_command(CMD_DEL_FIRST, 32'hFFFF_FFFF);
        issue_command(CMD_APPEND,    32'hFFFF_FFFF);
        issue_command(CMD_DEL_ALL,   32'hFFFF_FFFF);
        issue_command(CMD_DEL_ALL,   32'h0000_0000);
        issue_command(CMD_UNUSED,          32'h0000_0001);
        issue_command(CMD_UNUSED + 3'd1,   32'h8000_0000);
        issue_command(CMD_UNUSED + 3'd2,   32'hFFFF_FFFF);
        issue_command(CMD_DEL_FIRST, 32'h5555_5555);
        issue_command(CMD_DEL_FIRST, 32'hAAAA_AAAA);

        // Random: runs that fill the list, drain it or mix, over a small value pool.
        n = 0;
        while (n < RANDOM_ITEMS) begin
            mode    = $urandom_range(MODE_MIXED);
            run_len = $urandom_range(8, 40);
            pool_n  = $urandom_range(1, 4);
            foreach (value_pool[k])
                value_pool[k] = ($urandom_range(99) < 15) ? pick_extreme() : VAL_W'($urandom);
            repeat (run_len) begin
                no_idle = (n >= QUIET_FROM && n < QUIET_TO);
                issue_command(pick_command(mode), pick_value());
                n++;
            end
        end
        cmd_ch.valid <= 1'b0;
        no_idle = 1'b0;

        // let the checker record the last accepted item before waiting on it
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d commands and checked %0d result items;", items_sent, results);
        $display("%0d inserts hit a full list, %0d entries were deleted.", overflows, deleted);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
